// ----- src/zupt_stance_swing_detector_core_assert.svh -----
// Assertion macros for the stance/swing detector core.
// Every macro assumes a clock named clk and an active-low reset named rst_n.
`ifndef ZUPT_STANCE_SWING_DETECTOR_CORE_ASSERT_SVH
`define ZUPT_STANCE_SWING_DETECTOR_CORE_ASSERT_SVH

// When ante holds, cons must hold at the same edge.
`define ZSSD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cond must never hold.
`define ZSSD_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ----- src/zssd_pkg.sv -----
// Shared types and constants for the stance/swing detector core.
// No dependencies; every module of the core imports this package.
package zssd_pkg;

  localparam int RATEW      = 16;   // one gyro rate sample
  localparam int TRIW       = 18;   // sum of three IMU rates on one axis
  localparam int AVGW       = 21;   // averaged-rate output field
  localparam int ENW        = 46;   // energy output field and threshold
  localparam int CNTW       = 8;    // interval counter
  localparam int NRATE      = 9;    // three IMUs times three axes
  localparam int RING_DEF   = 8;
  localparam int WINDOW_DEF = 16;
  localparam int QDEPTH     = 4;    // front-to-back queue entries
  localparam int CFG_AW     = 4;
  localparam int CFG_DW     = 64;

  localparam int AVG_MAX = 1048575;
  localparam int AVG_MIN = -1048576;

  localparam logic [ENW-1:0]  ENERGY_MAX   = '1;
  localparam logic [CNTW-1:0] CNT_MAX      = '1;
  localparam logic [CNTW-1:0] INTERVAL_RST = 8'd5;

  localparam logic CMD_PROCESS = 1'b0;
  localparam logic CMD_PRIME   = 1'b1;

  localparam logic PHASE_STANCE = 1'b0;
  localparam logic PHASE_SWING  = 1'b1;

  // Register index, taken from bit 3 of the byte address (8-byte stride).
  typedef enum logic {
    REG_ENERGY_THR   = 1'b0,
    REG_INTERVAL_THR = 1'b1
  } zssd_reg_t;

  typedef struct packed {
    logic [ENW-1:0]  energy_thr;
    logic [CNTW-1:0] interval_thr;
  } zssd_cfg_t;

  // Detector status seen by the top level.
  typedef struct packed {
    logic            phase;
    logic [CNTW-1:0] count;
    logic            prime;   // item in the output register was a prime
  } zssd_stat_t;

endpackage

// ----- src/zssd_front.sv -----
// Front end: forms per-axis triple sums and keeps the rate ring and its running sums.
// Depends on zssd_pkg.
module zssd_front import zssd_pkg::*; #(
  parameter int RING = RING_DEF,
  localparam int SUMW = TRIW + $clog2(RING),
  localparam int RPW  = (RING > 1) ? $clog2(RING) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         take,
  input  logic                         cmd,
  input  logic [NRATE-1:0][RATEW-1:0]  rate,
  output logic signed [SUMW-1:0]       sum_x,
  output logic signed [SUMW-1:0]       sum_y,
  output logic signed [SUMW-1:0]       sum_z
);

  localparam logic signed [SUMW-1:0] RING_S = SUMW'(RING);
  localparam logic [RPW-1:0]         PTR_LAST = RPW'(RING - 1);

  logic signed [TRIW-1:0] tri_x, tri_y, tri_z;
  logic [3*TRIW-1:0]      tri_all;

  logic [3*TRIW-1:0] ring_mem [RING];
  logic [3*TRIW-1:0] ring_rd_r;
  logic [3*TRIW-1:0] prime_r, prime_nxt;
  logic [RING-1:0]   vld_r, vld_nxt;
  logic [RPW-1:0]    ptr_r, ptr_nxt;
  logic              wr_en;

  logic [3*TRIW-1:0]      old_all;
  logic signed [TRIW-1:0] old_x, old_y, old_z;

  logic signed [SUMW-1:0] sum_x_r, sum_y_r, sum_z_r;
  logic signed [SUMW-1:0] sum_x_nxt, sum_y_nxt, sum_z_nxt;

  always_comb begin
    tri_x = TRIW'($signed(rate[0])) + TRIW'($signed(rate[3])) + TRIW'($signed(rate[6]));
    tri_y = TRIW'($signed(rate[1])) + TRIW'($signed(rate[4])) + TRIW'($signed(rate[7]));
    tri_z = TRIW'($signed(rate[2])) + TRIW'($signed(rate[5])) + TRIW'($signed(rate[8]));
    tri_all = {tri_x, tri_y, tri_z};
  end

  // Entries not written since the last prime hold the primed value.
  always_comb begin
    old_all = vld_r[ptr_r] ? ring_rd_r : prime_r;
    old_x = $signed(old_all[3*TRIW-1 -: TRIW]);
    old_y = $signed(old_all[2*TRIW-1 -: TRIW]);
    old_z = $signed(old_all[TRIW-1:0]);
  end

  always_comb begin
    wr_en     = 1'b0;
    ptr_nxt   = ptr_r;
    vld_nxt   = vld_r;
    prime_nxt = prime_r;
    sum_x_nxt = sum_x_r;
    sum_y_nxt = sum_y_r;
    sum_z_nxt = sum_z_r;
    if (take) begin
      if (cmd == CMD_PRIME) begin
        ptr_nxt   = '0;
        vld_nxt   = '0;
        prime_nxt = tri_all;
        sum_x_nxt = SUMW'(tri_x) * RING_S;
        sum_y_nxt = SUMW'(tri_y) * RING_S;
        sum_z_nxt = SUMW'(tri_z) * RING_S;
      end else begin
        wr_en          = 1'b1;
        vld_nxt[ptr_r] = 1'b1;
        ptr_nxt        = (ptr_r == PTR_LAST) ? '0 : ptr_r + 1'b1;
        sum_x_nxt      = sum_x_r + SUMW'(tri_x) - SUMW'(old_x);
        sum_y_nxt      = sum_y_r + SUMW'(tri_y) - SUMW'(old_y);
        sum_z_nxt      = sum_z_r + SUMW'(tri_z) - SUMW'(old_z);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r   <= '0;
      vld_r   <= '0;
      prime_r <= '0;
      sum_x_r <= '0;
      sum_y_r <= '0;
      sum_z_r <= '0;
    end else begin
      ptr_r   <= ptr_nxt;
      vld_r   <= vld_nxt;
      prime_r <= prime_nxt;
      sum_x_r <= sum_x_nxt;
      sum_y_r <= sum_y_nxt;
      sum_z_r <= sum_z_nxt;
    end
  end

  // Prefetch the entry the next item will replace; forward a same-address write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[ptr_r] <= tri_all;
    end
    if (wr_en && ptr_r == ptr_nxt) begin
      ring_rd_r <= tri_all;
    end else begin
      ring_rd_r <= ring_mem[ptr_nxt];
    end
  end

  assign sum_x = sum_x_nxt;
  assign sum_y = sum_y_nxt;
  assign sum_z = sum_z_nxt;

endmodule

// ----- src/zssd_queue.sv -----
// Short register FIFO between the front end and the back end.
// Depends on zssd_pkg.
module zssd_queue import zssd_pkg::*; #(
  parameter int DW    = 8,
  parameter int DEPTH = QDEPTH,
  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  input  logic          pop,
  output logic [DW-1:0] head,
  output logic          full,
  output logic          empty
);

  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [DW-1:0] slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign head  = slot_r[rd_ptr_r];
  assign full  = (cnt_r == CNT_FULL);
  assign empty = (cnt_r == '0);

endmodule

// ----- src/zssd_back.sv -----
// Back end: squares the ring sums, keeps the energy window, runs the phase
// counter and holds the output register. Depends on zssd_pkg.
module zssd_back import zssd_pkg::*; #(
  parameter int RING   = RING_DEF,
  parameter int WINDOW = WINDOW_DEF,
  localparam int SUMW  = TRIW + $clog2(RING),
  localparam int QW    = 1 + 3 * SUMW
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_empty,
  input  logic [QW-1:0]           q_head,
  output logic                    q_pop,
  input  zssd_cfg_t               cfg,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_phase,
  output logic [ENW-1:0]          out_window_energy,
  output logic signed [AVGW-1:0]  out_avg_rate_x,
  output logic signed [AVGW-1:0]  out_avg_rate_y,
  output logic signed [AVGW-1:0]  out_avg_rate_z,
  output zssd_stat_t              stat
);

  localparam int SQW  = 2 * SUMW;
  localparam int MAGW = SQW + 2;
  localparam int ESW  = MAGW + $clog2(WINDOW);
  localparam int CMPW = (ESW > ENW) ? ESW : ENW;
  localparam int AVW  = (SUMW > AVGW) ? SUMW : AVGW;
  localparam int WPW  = $clog2(WINDOW);
  localparam logic [WPW-1:0]        WP_LAST = WPW'(WINDOW - 1);
  localparam logic signed [AVW-1:0] AV_MAX  = AVW'(AVG_MAX);
  localparam logic signed [AVW-1:0] AV_MIN  = AVW'(AVG_MIN);

  function automatic logic signed [AVGW-1:0] sat_avg(input logic signed [SUMW-1:0] v);
    logic signed [AVW-1:0] w;
    w = AVW'(v);
    if (w > AV_MAX) begin
      sat_avg = AV_MAX[AVGW-1:0];
    end else if (w < AV_MIN) begin
      sat_avg = AV_MIN[AVGW-1:0];
    end else begin
      sat_avg = w[AVGW-1:0];
    end
  endfunction

  logic adv;

  // Queue head fields.
  logic                   h_cmd;
  logic signed [SUMW-1:0] h_x, h_y, h_z;
  logic signed [SQW-1:0]  prod_x, prod_y, prod_z;

  // Stage 1: squares.
  logic                   s1_v_r, s1_prime_r;
  logic signed [SUMW-1:0] s1_x_r, s1_y_r, s1_z_r;
  logic [SQW-1:0]         s1_sq_x_r, s1_sq_y_r, s1_sq_z_r;

  // Stage 2: window update.
  logic                   s2_v_r, s2_prime_r;
  logic signed [SUMW-1:0] s2_x_r, s2_y_r, s2_z_r;

  logic [MAGW-1:0]   mag, old_mag;
  logic [MAGW-1:0]   win_mem [WINDOW];
  logic [MAGW-1:0]   win_rd_r;
  logic [WINDOW-1:0] wvld_r, wvld_nxt;
  logic [WPW-1:0]    wp_r, wp_nxt;
  logic [ESW-1:0]    esum_r, esum_nxt;
  logic              win_wr;

  // Phase tracking.
  logic            phase_r, phase_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt, cnt_up, cnt_dn;
  logic            swing;
  logic            s3_load;

  // Output register.
  logic                   out_v_r;
  logic                   out_prime_r;
  logic                   out_phase_r;
  logic [ENW-1:0]         out_energy_r;
  logic signed [AVGW-1:0] out_x_r, out_y_r, out_z_r;

  // Advance the whole back pipeline unless a finished item is stuck at the output.
  assign adv   = !out_v_r || out_ready;
  assign q_pop = adv && !q_empty;

  always_comb begin
    h_cmd  = q_head[QW-1];
    h_x    = $signed(q_head[3*SUMW-1 -: SUMW]);
    h_y    = $signed(q_head[2*SUMW-1 -: SUMW]);
    h_z    = $signed(q_head[SUMW-1:0]);
    prod_x = h_x * h_x;
    prod_y = h_y * h_y;
    prod_z = h_z * h_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= !q_empty;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_prime_r <= (h_cmd == CMD_PRIME);
      s1_x_r     <= h_x;
      s1_y_r     <= h_y;
      s1_z_r     <= h_z;
      s1_sq_x_r  <= $unsigned(prod_x);
      s1_sq_y_r  <= $unsigned(prod_y);
      s1_sq_z_r  <= $unsigned(prod_z);
    end
    if (adv && s1_v_r) begin
      s2_prime_r <= s1_prime_r;
      s2_x_r     <= s1_x_r;
      s2_y_r     <= s1_y_r;
      s2_z_r     <= s1_z_r;
    end
  end

  // Window: drop the oldest energy, add the new one; a prime clears it. Unwritten slots read as zero.
  always_comb begin
    mag      = MAGW'(s1_sq_x_r) + MAGW'(s1_sq_y_r) + MAGW'(s1_sq_z_r);
    old_mag  = wvld_r[wp_r] ? win_rd_r : '0;
    win_wr   = 1'b0;
    wp_nxt   = wp_r;
    wvld_nxt = wvld_r;
    esum_nxt = esum_r;
    if (adv && s1_v_r) begin
      if (s1_prime_r) begin
        wp_nxt   = '0;
        wvld_nxt = '0;
        esum_nxt = '0;
      end else begin
        win_wr        = 1'b1;
        wvld_nxt[wp_r] = 1'b1;
        wp_nxt        = (wp_r == WP_LAST) ? '0 : wp_r + 1'b1;
        esum_nxt      = esum_r - ESW'(old_mag) + ESW'(mag);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      wvld_r <= '0;
      esum_r <= '0;
    end else begin
      wp_r   <= wp_nxt;
      wvld_r <= wvld_nxt;
      esum_r <= esum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (win_wr) begin
      win_mem[wp_r] <= mag;
    end
    win_rd_r <= win_mem[wp_nxt];
  end

  // Phase hysteresis on the energy of the item in stage 2.
  assign swing   = CMPW'(esum_r) >= CMPW'(cfg.energy_thr);
  assign cnt_up  = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
  assign cnt_dn  = (cnt_r == '0) ? cnt_r : cnt_r - 1'b1;
  assign s3_load = adv && s2_v_r;

  always_comb begin
    cnt_nxt   = cnt_r;
    phase_nxt = phase_r;
    if (s3_load) begin
      if (s2_prime_r) begin
        cnt_nxt   = '0;
        phase_nxt = PHASE_STANCE;
      end else if (swing && phase_r == PHASE_STANCE) begin
        cnt_nxt   = cnt_up;
        phase_nxt = (cnt_up >= cfg.interval_thr) ? PHASE_SWING : PHASE_STANCE;
      end else if (!swing && phase_r == PHASE_SWING) begin
        cnt_nxt   = cnt_dn;
        phase_nxt = (cnt_dn == '0) ? PHASE_STANCE : PHASE_SWING;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PHASE_STANCE;
      cnt_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      if (adv) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_load) begin
      out_prime_r  <= s2_prime_r;
      out_phase_r  <= phase_nxt;
      out_energy_r <= (CMPW'(esum_r) > CMPW'(ENERGY_MAX)) ? ENERGY_MAX : ENW'(esum_r);
      out_x_r      <= sat_avg(s2_x_r);
      out_y_r      <= sat_avg(s2_y_r);
      out_z_r      <= sat_avg(s2_z_r);
    end
  end

  assign out_valid         = out_v_r;
  assign out_phase         = out_phase_r;
  assign out_window_energy = out_energy_r;
  assign out_avg_rate_x    = out_x_r;
  assign out_avg_rate_y    = out_y_r;
  assign out_avg_rate_z    = out_z_r;

  assign stat.phase = phase_r;
  assign stat.count = cnt_r;
  assign stat.prime = out_prime_r;

endmodule

// ----- src/zupt_stance_swing_detector_core.sv -----
// An accepted item passes through the queue, stage 1 (squares), stage 2 (window) and the output register.
// Throughput: one item per cycle while neither side stalls; each item is a fixed running-sum update, no iteration.
// The front end stalls only when the 4-entry queue is full; the back end only on out_ready.
// Reset (synchronous, rst_n low): ring and window read as zero, pointers, energy sum,
// phase (stance) and counter cleared, energy threshold 0, interval threshold 5.
`include "zupt_stance_swing_detector_core_assert.svh"

module zupt_stance_swing_detector_core import zssd_pkg::*; #(
  parameter int RING   = RING_DEF,
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,

  // Configuration port, APB style, 64-bit data, registers at an 8-byte stride.
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CFG_AW-1:0]       paddr,
  input  logic [CFG_DW-1:0]       pwdata,
  output logic [CFG_DW-1:0]       prdata,
  output logic                    pready,

  // Input items.
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_cmd,
  input  logic signed [RATEW-1:0] in_imu0_rate_x,
  input  logic signed [RATEW-1:0] in_imu0_rate_y,
  input  logic signed [RATEW-1:0] in_imu0_rate_z,
  input  logic signed [RATEW-1:0] in_imu1_rate_x,
  input  logic signed [RATEW-1:0] in_imu1_rate_y,
  input  logic signed [RATEW-1:0] in_imu1_rate_z,
  input  logic signed [RATEW-1:0] in_imu2_rate_x,
  input  logic signed [RATEW-1:0] in_imu2_rate_y,
  input  logic signed [RATEW-1:0] in_imu2_rate_z,

  // Result items.
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_phase,
  output logic [ENW-1:0]          out_window_energy,
  output logic signed [AVGW-1:0]  out_avg_rate_x,
  output logic signed [AVGW-1:0]  out_avg_rate_y,
  output logic signed [AVGW-1:0]  out_avg_rate_z
);

  localparam int SUMW = TRIW + $clog2(RING);
  localparam int QW   = 1 + 3 * SUMW;

  // ---------------------------------------------------------------------------
  // Configuration registers. pready is tied high, so a write lands in the access
  // cycle. The register index is bit 3 of the byte address.
  // ---------------------------------------------------------------------------
  logic      cfg_wr;
  zssd_reg_t cfg_idx;
  zssd_cfg_t cfg_r, cfg_nxt;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = zssd_reg_t'(paddr[3]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_ENERGY_THR:   cfg_nxt.energy_thr   = pwdata[ENW-1:0];
        REG_INTERVAL_THR: cfg_nxt.interval_thr = pwdata[CNTW-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.energy_thr   <= '0;
      cfg_r.interval_thr <= INTERVAL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ENERGY_THR:   prdata = CFG_DW'(cfg_r.energy_thr);
      REG_INTERVAL_THR: prdata = CFG_DW'(cfg_r.interval_thr);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Front end: accept an item whenever the queue has room, update the ring and
  // its running sums in the accept cycle, and push the new sums with the command.
  // ---------------------------------------------------------------------------
  logic                        take;
  logic [NRATE-1:0][RATEW-1:0] rates;
  logic signed [SUMW-1:0]      f_sum_x, f_sum_y, f_sum_z;
  logic                        q_full, q_empty, q_pop;
  logic [QW-1:0]               q_head;

  assign take     = in_valid && in_ready;
  assign in_ready = !q_full;

  // IMU-major order: x, y, z of IMU 0, then IMU 1, then IMU 2.
  assign rates = {in_imu2_rate_z, in_imu2_rate_y, in_imu2_rate_x,
                  in_imu1_rate_z, in_imu1_rate_y, in_imu1_rate_x,
                  in_imu0_rate_z, in_imu0_rate_y, in_imu0_rate_x};

  zssd_front #(
    .RING (RING)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .cmd   (in_cmd),
    .rate  (rates),
    .sum_x (f_sum_x),
    .sum_y (f_sum_y),
    .sum_z (f_sum_z)
  );

  // Queue decouples the front from the back: each side stalls on its own.
  zssd_queue #(
    .DW    (QW),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take),
    .push_data ({in_cmd, f_sum_x, f_sum_y, f_sum_z}),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // ---------------------------------------------------------------------------
  // Back end: square, window energy, phase counter, output register.
  // ---------------------------------------------------------------------------
  zssd_stat_t stat;

  zssd_back #(
    .RING   (RING),
    .WINDOW (WINDOW)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .cfg               (cfg_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_phase         (out_phase),
    .out_window_energy (out_window_energy),
    .out_avg_rate_x    (out_avg_rate_x),
    .out_avg_rate_y    (out_avg_rate_y),
    .out_avg_rate_z    (out_avg_rate_z),
    .stat              (stat)
  );

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // Swing is only reached through a nonzero counter and left when it hits zero.
  `ZSSD_ASSERT_NEVER(a_swing_zero_count, stat.phase == PHASE_SWING && stat.count == '0, "swing phase with zero interval count")
  // A primed result shows stance and an empty window.
  `ZSSD_ASSERT_IMP(a_prime_result, out_valid && stat.prime, out_phase == PHASE_STANCE && out_window_energy == '0, "prime result not cleared")
  // Entering swing needs the counter at or above the interval threshold.
  `ZSSD_ASSERT_IMP(a_swing_entry, $rose(stat.phase), stat.count >= cfg_r.interval_thr, "swing entered below interval threshold")

endmodule
